### rtl/core/ssa_pkg.sv
// Shared types, constants and codes of the symbol slot allocator.
// No dependencies; imported by the allocator core and its testbench.
`default_nettype none

package ssa_pkg;

    localparam int SLOT_COUNT     = 1024;
    localparam int TERMINAL_LIMIT = 256;
    localparam int SLOT_W         = $clog2(SLOT_COUNT);
    localparam int BUMP_W         = SLOT_W + 1;
    localparam int VALUE_W        = 16;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;

    // stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W    = VALUE_W + 1 + SLOT_W + SLOT_W;
    localparam int IN_DATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W     = ((SLOT_W + 7) / 8) * 8;
    localparam int USER_W         = 8;

    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam mode_t MODE_ALLOC   = 2'd0;
    localparam mode_t MODE_RECYCLE = 2'd1;
    localparam mode_t MODE_CLEAR   = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EXHAUSTED = 2'd1;
    localparam status_t ST_TERM_RULE = 2'd2;

    // one entry of the link store: end-of-list mark and next free slot
    typedef struct packed {
        logic  last;
        slot_t next;
    } link_t;

    localparam int LINK_W = $bits(link_t);

endpackage

`default_nettype wire

### rtl/core/symbol_slot_allocator_core.sv
// Top level of the symbol slot allocator: request decode, free list and result register.
// Depends on ssa_pkg and ssa_ram.
`default_nettype none

// Hands out slot indices of a store of SLOT_COUNT slots. Each request is one
// transfer on the slave stream (tuser carries the request kind) and yields
// exactly one result transfer on the master stream. Allocate pops the most
// recently recycled slot from a LIFO free list linked through an on-chip
// link RAM; with the list empty it takes the next never-used slot from a bump
// counter. Exhaustion (status 1) is reported only when the list is empty and
// the counter has reached SLOT_COUNT; a terminal value (below TERMINAL_LIMIT)
// naming a rule is rejected with status 2. Recycle pushes a slot, clear
// forgets every allocation, and both answer granted slot 0, status 0.
// Throughput: one request per cycle for recycle, clear, rejected and bump
// allocations; an allocate that pops the free list stalls the next request,
// because the link of the new list head must come back from the registered
// read port of the link RAM first. The head's own link is held in a
// register, so a pop never waits for memory itself. A result waiting on the
// master side does not stop the next request from being taken as long as the
// result register is drained in the same cycle. No clearing pass after reset.

module symbol_slot_allocator_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, low to high: sym_value[15:0], rule_present, rule_slot[9:0],
    // free_slot[9:0], zero pad
    input  wire logic [ssa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser, low to high: mode[1:0], zero pad
    input  wire logic [ssa_pkg::USER_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata, low to high: granted_slot[9:0], zero pad
    output logic      [ssa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser, low to high: status[1:0], zero pad
    output logic      [ssa_pkg::USER_W-1:0]       m_axis_tuser
);

    import ssa_pkg::*;

    // request fields
    mode_t                mode;
    logic [VALUE_W-1:0]   sym_value;
    logic                 rule_present;
    slot_t                free_slot;

    // free list and bump counter
    slot_t                head_reg,  head_next;
    logic                 empty_reg, empty_next;
    link_t                hlink_reg, hlink_next;   // link entry of the head slot
    logic [BUMP_W-1:0]    bump_reg,  bump_next;
    logic                 wait_reg,  wait_next;    // link RAM read in flight

    // result register
    logic                 ovalid_reg, ovalid_next;
    slot_t                gslot_reg,  gslot_next;
    status_t              status_reg, status_next;

    logic                 accept;
    logic                 pop;
    logic                 ram_wr_en;
    link_t                ram_wr_data;
    link_t                ram_rd_data;

    assign mode         = s_axis_tuser[MODE_W-1:0];
    assign sym_value    = s_axis_tdata[VALUE_W-1:0];
    assign rule_present = s_axis_tdata[VALUE_W];
    // rule_slot sits at [VALUE_W+SLOT_W:VALUE_W+1]; its count lives outside this core
    assign free_slot    = s_axis_tdata[VALUE_W+2*SLOT_W:VALUE_W+SLOT_W+1];

    assign s_axis_tready = (!ovalid_reg || m_axis_tready) && !wait_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - SLOT_W)'(0), gslot_reg};
    assign m_axis_tuser  = {(USER_W - STATUS_W)'(0), status_reg};

    always_comb
    begin
        head_next   = head_reg;
        empty_next  = empty_reg;
        hlink_next  = hlink_reg;
        bump_next   = bump_reg;
        wait_next   = 1'b0;
        ovalid_next = ovalid_reg && !m_axis_tready;
        gslot_next  = gslot_reg;
        status_next = status_reg;
        pop         = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_data = '{last: empty_reg, next: head_reg};

        // head link comes back from RAM the cycle after a pop
        if (wait_reg)
        begin
            hlink_next = ram_rd_data;
        end

        if (accept)
        begin
            ovalid_next = 1'b1;
            gslot_next  = '0;
            status_next = ST_OK;
            unique case (mode)
                MODE_ALLOC:
                begin
                    if (empty_reg && bump_reg == BUMP_W'(SLOT_COUNT))
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else if (rule_present && sym_value < VALUE_W'(TERMINAL_LIMIT))
                    begin
                        status_next = ST_TERM_RULE;
                    end
                    else if (!empty_reg)
                    begin
                        pop        = 1'b1;
                        gslot_next = head_reg;
                        head_next  = hlink_reg.next;
                        empty_next = hlink_reg.last;
                        wait_next  = 1'b1;
                    end
                    else
                    begin
                        gslot_next = bump_reg[SLOT_W-1:0];
                        bump_next  = bump_reg + BUMP_W'(1);
                    end
                end
                MODE_RECYCLE:
                begin
                    // old head becomes the link of the pushed slot
                    ram_wr_en  = 1'b1;
                    hlink_next = ram_wr_data;
                    head_next  = free_slot;
                    empty_next = 1'b0;
                end
                MODE_CLEAR:
                begin
                    head_next  = '0;
                    empty_next = 1'b1;
                    bump_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            empty_reg  <= 1'b1;
            bump_reg   <= '0;
            wait_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            empty_reg  <= empty_next;
            bump_reg   <= bump_next;
            wait_reg   <= wait_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hlink_reg  <= hlink_next;
        gslot_reg  <= gslot_next;
        status_reg <= status_next;
    end

    ssa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOT_COUNT)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (free_slot),
        .wr_data (ram_wr_data),
        .rd_en   (pop),
        .rd_addr (hlink_reg.next),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTHESIS
    a_wait_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg |-> !s_axis_tready)
        else $error("request taken while link read in flight");

    a_wait_one: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg |=> !wait_reg)
        else $error("link read wait longer than one cycle");

    a_pop_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_ALLOC && !empty_reg
         && !(rule_present && sym_value < VALUE_W'(TERMINAL_LIMIT))) |=> wait_reg)
        else $error("pop without link refetch");

    a_bump_range: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= BUMP_W'(SLOT_COUNT))
        else $error("bump counter past slot count");

    a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && status_reg != ST_OK) |-> gslot_reg == '0)
        else $error("failed allocate reports a slot");
`endif

endmodule

`default_nettype wire

### rtl/core/ssa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### dv/symbol_slot_allocator_core_tb.sv
// Self-checking testbench for symbol_slot_allocator_core: directed and random
// allocate / recycle / clear traffic with a free-list and bump-counter predictor.
// Depends on ssa_pkg and the allocator RTL.
`default_nettype none

module symbol_slot_allocator_core_tb;

    import ssa_pkg::*;

    // request kind with no meaning; the block answers slot 0, status ok
    localparam mode_t MODE_NOP = 2'd3;

    typedef struct packed {
        mode_t               mode;
        logic [VALUE_W-1:0]  value;
        logic                rule_present;
        slot_t               rule_slot;
        slot_t               free_slot;
    } slot_request_t;

    typedef struct packed {
        slot_t   slot;
        status_t status;
    } slot_grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [USER_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [USER_W-1:0]     m_axis_tuser;

    symbol_slot_allocator_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    slot_request_t pending_reqs[$];
    slot_grant_t   expected_grants[$];
    int            errors = 0;
    bit            no_idle = 1'b0;

    // ------------------------------------------------------------------
    // Allocator shadow: free list, bump counter, reference counts
    // ------------------------------------------------------------------
    link_t              link_mem[SLOT_COUNT];
    logic [15:0]        refcount[SLOT_COUNT];
    bit                 count_known[SLOT_COUNT];
    slot_t              known_slots[$];     // slots whose count has been written
    logic [BUMP_W-1:0]  bump_next = '0;
    slot_t              list_head = '0;
    bit                 list_empty = 1'b1;

    function automatic slot_grant_t predict_grant(input slot_request_t r);
        slot_grant_t g;
        slot_t       s;
        g.slot   = '0;
        g.status = ST_OK;
        case (r.mode)
            MODE_ALLOC:
            begin
                // exhaustion wins over the terminal-with-rule rejection
                if (list_empty && bump_next >= SLOT_COUNT)
                    g.status = ST_EXHAUSTED;
                else if (r.value < TERMINAL_LIMIT && r.rule_present)
                    g.status = ST_TERM_RULE;
                else
                begin
                    if (r.rule_present)
                        refcount[r.rule_slot] = refcount[r.rule_slot] + 16'd1;
                    if (!list_empty)
                    begin
                        s          = list_head;
                        list_head  = link_mem[s].next;
                        list_empty = link_mem[s].last;
                    end
                    else
                    begin
                        s         = bump_next[SLOT_W-1:0];
                        bump_next = bump_next + 1'b1;
                    end
                    // new slot's zero count overrides a self-referencing increment
                    refcount[s] = '0;
                    if (!count_known[s])
                    begin
                        count_known[s] = 1'b1;
                        known_slots.push_back(s);
                    end
                    g.slot = s;
                end
            end
            MODE_RECYCLE:
            begin
                link_mem[r.free_slot].last = list_empty;
                link_mem[r.free_slot].next = list_head;
                list_head  = r.free_slot;
                list_empty = 1'b0;
            end
            MODE_CLEAR:
            begin
                bump_next  = '0;
                list_head  = '0;
                list_empty = 1'b1;
            end
            default: ;
        endcase
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // rule slots are drawn from slots with a written count, or slot 0 while there are none
    function automatic slot_t known_slot();
        if (known_slots.size() == 0)
            return '0;
        return known_slots[$urandom_range(known_slots.size() - 1)];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic add_req(input mode_t m, input logic [15:0] v, input logic rp,
                           input slot_t rs, input slot_t fs);
        slot_request_t r;
        r.mode         = m;
        r.value        = v;
        r.rule_present = rp;
        r.rule_slot    = rs;
        r.free_slot    = fs;
        pending_reqs.push_back(r);
    endtask

    // allocate; a rejected one is a terminal value that names a rule
    task automatic add_alloc(input bit reject);
        logic       rp;
        logic [15:0] v;
        if (reject)
        begin
            rp = 1'b1;
            v  = 16'($urandom_range(TERMINAL_LIMIT - 1));
        end
        else
        begin
            rp = known_slots.size() != 0 && $urandom_range(1) == 1;
            if (rp)
                v = 16'($urandom_range(65535, TERMINAL_LIMIT));
            else if ($urandom_range(2) == 0)
                v = 16'($urandom_range(TERMINAL_LIMIT - 1));
            else
                v = 16'($urandom_range(65535));
        end
        add_req(MODE_ALLOC, v, rp, known_slot(), slot_t'($urandom_range(SLOT_COUNT - 1)));
    endtask

    task automatic add_other(input mode_t m);
        slot_t fs;
        fs = ($urandom_range(9) < 6 && known_slots.size() != 0)
             ? known_slot() : slot_t'($urandom_range(SLOT_COUNT - 1));
        add_req(m, 16'($urandom_range(65535)), 1'($urandom_range(1)), known_slot(), fs);
    endtask

    task automatic add_mixed(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 45)
                add_alloc($urandom_range(7) == 0);
            else if (r < 80)
                add_other(MODE_RECYCLE);
            else if (r < 92)
                add_other(MODE_CLEAR);
            else
                add_other(MODE_NOP);
        end
    endtask

    // empty the list, run the bump counter to the end of the store, then
    // keep poking at the exhausted state with recycles and allocates
    task automatic add_fill_to_exhaustion();
        int bumped;
        int r;
        bumped = 0;
        add_other(MODE_CLEAR);
        while (bumped < SLOT_COUNT)
        begin
            r = $urandom_range(99);
            if (r < 7)
            begin
                add_other(MODE_RECYCLE);
                add_alloc(1'b0);        // pops the slot just pushed
            end
            else if (r < 11)
                add_alloc(1'b1);
            else if (r < 13)
                add_other(MODE_NOP);
            else
            begin
                add_alloc(1'b0);
                bumped++;
            end
        end
        repeat (30)
        begin
            r = $urandom_range(99);
            if (r < 35)
                add_other(MODE_RECYCLE);
            else
                add_alloc(r > 85);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_grants.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: one request per transfer on the slave stream
    // ------------------------------------------------------------------
    slot_request_t in_flight;
    int            send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_grants.push_back(predict_grant(in_flight));
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                in_flight = pending_reqs.pop_front();
                s_axis_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, in_flight.free_slot,
                                 in_flight.rule_slot, in_flight.rule_present, in_flight.value};
                s_axis_tuser  <= {{(USER_W - MODE_W){1'b0}}, in_flight.mode};
                s_axis_tvalid <= 1'b1;
                send_gap = pick_gap();
                // occasionally switch to a back-to-back stretch and back
                if ($urandom_range(149) == 0)
                    no_idle = !no_idle;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, check every result transfer
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        slot_grant_t exp_g;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("result with nothing expected: granted_slot %0d status %0d",
                           m_axis_tdata[SLOT_W-1:0], m_axis_tuser[STATUS_W-1:0]);
                    errors++;
                end
                else
                begin
                    exp_g = expected_grants.pop_front();
                    if (m_axis_tdata[SLOT_W-1:0] !== exp_g.slot)
                    begin
                        $error("granted_slot: expected %0d, actual %0d",
                               exp_g.slot, m_axis_tdata[SLOT_W-1:0]);
                        errors++;
                    end
                    if (m_axis_tuser[STATUS_W-1:0] !== exp_g.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               exp_g.status, m_axis_tuser[STATUS_W-1:0]);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every request kind, corner cases
        add_req(MODE_NOP,     16'hFFFF, 1'b0, 10'd0,    10'd1023);
        add_req(MODE_ALLOC,   16'hFFFF, 1'b0, 10'd0,    10'd0);     // bump -> 0
        add_req(MODE_ALLOC,   16'd256,  1'b1, 10'd0,    10'd0);     // lowest non-terminal
        add_req(MODE_ALLOC,   16'd255,  1'b1, 10'd0,    10'd0);     // terminal with rule
        add_req(MODE_ALLOC,   16'd0,    1'b0, 10'd0,    10'd0);     // terminal, no rule
        add_req(MODE_RECYCLE, 16'd0,    1'b0, 10'd0,    10'd1);
        add_req(MODE_RECYCLE, 16'd0,    1'b0, 10'd0,    10'd2);
        add_req(MODE_ALLOC,   16'h1234, 1'b0, 10'd0,    10'd0);     // LIFO: 2 first
        add_req(MODE_ALLOC,   16'h8000, 1'b1, 10'd1,    10'd0);     // rule is granted slot
        add_req(MODE_ALLOC,   16'hFFFF, 1'b1, 10'd0,    10'd0);     // list empty again
        add_req(MODE_RECYCLE, 16'd0,    1'b0, 10'd0,    10'd3);
        add_req(MODE_RECYCLE, 16'd0,    1'b0, 10'd0,    10'd3);     // double recycle
        add_req(MODE_ALLOC,   16'h0F0F, 1'b0, 10'd0,    10'd0);
        add_req(MODE_ALLOC,   16'hF0F0, 1'b0, 10'd0,    10'd0);
        add_req(MODE_CLEAR,   16'hFFFF, 1'b1, 10'd0,    10'd1023);
        add_req(MODE_RECYCLE, 16'hFFFF, 1'b0, 10'd0,    10'd1023);
        add_req(MODE_ALLOC,   16'h00FF, 1'b0, 10'd0,    10'd0);     // pops top slot
        add_req(MODE_ALLOC,   16'hFFFF, 1'b1, 10'd1023, 10'd0);     // bump restarted
        add_req(MODE_ALLOC,   16'd255,  1'b1, 10'd1023, 10'd1023);
        add_req(MODE_NOP,     16'hFFFF, 1'b1, 10'd1023, 10'd1023);
        add_req(MODE_RECYCLE, 16'hFFFF, 1'b1, 10'd1023, 10'd0);
        add_req(MODE_ALLOC,   16'h0100, 1'b1, 10'd0,    10'd0);     // rule is granted slot
        // sender holds off until every result is back
        wait_drained();

        add_mixed(70);
        wait_drained();
        add_fill_to_exhaustion();
        wait_drained();
        add_mixed(70);
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
